>>> src/lpcs_pkg.sv
`timescale 1ns / 1ps
// Package: widths, constants, microcode format and program, excitation tables.
package lpcs_pkg;

    localparam int ORDER     = 8;
    localparam int PULSE_LEN = 15;
    localparam int NREFL     = 8;

    localparam int LW    = $clog2(ORDER);
    localparam int PIW   = $clog2(PULSE_LEN + 1);
    localparam int PCW   = 12;
    localparam int PERW  = 11;
    localparam int EGW   = 15;
    localparam int CW    = 16;
    localparam int DW    = 32;
    localparam int BW    = 17;
    localparam int FINW  = 16;
    localparam int SAMPW = 21;

    localparam logic [DW-1:0]          LFSR_TAPS  = 32'h8020_0003;
    localparam logic signed [BW-1:0]   DEEMPH_K   = 17'sd29184;
    localparam logic signed [BW-1:0]   HIPASS_K   = 17'sd26542;
    localparam logic signed [FINW-1:0] NOISE_HALF = 16'sd5120;

    typedef logic [PIW-1:0]               t_pidx;
    typedef logic [PCW-1:0]               t_pcnt;
    typedef logic [LW-1:0]                t_loop;
    typedef logic [ORDER-1:0][CW-1:0]     t_coef_arr;
    typedef logic [ORDER-1:0][DW-1:0]     t_tap_arr;

    localparam t_loop LOOP_LAST = t_loop'(ORDER - 2);

    localparam int STEPS = 12;
    localparam int SW    = $clog2(STEPS);
    typedef logic [SW-1:0] t_step;

    localparam t_step ST_EXC    = t_step'(0);
    localparam t_step ST_C0     = t_step'(1);
    localparam t_step ST_C1     = t_step'(2);
    localparam t_step ST_LOOP   = t_step'(3);
    localparam t_step ST_SMUL   = t_step'(4);
    localparam t_step ST_SWR    = t_step'(5);
    localparam t_step ST_LAST   = t_step'(6);
    localparam t_step ST_DEEMPH = t_step'(7);
    localparam t_step ST_MIX    = t_step'(8);
    localparam t_step ST_KZ     = t_step'(9);
    localparam t_step ST_EMIT   = t_step'(10);
    localparam t_step ST_HP     = t_step'(11);

    typedef enum logic [2:0] {
        A_FINP,
        A_TAP0,
        A_TAP1,
        A_ACC_SH,
        A_DEEMPH,
        A_KZ_SH
    } t_asel;

    typedef enum logic [2:0] {
        B_EGAIN,
        B_COEF0,
        B_COEF1,
        B_OGAIN,
        B_DEEMPH_K,
        B_HIPASS_K
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB,
        ACC_ADD_SH4
    } t_accop;

    typedef enum logic [1:0] {
        TAP_HOLD,
        TAP_KEEP,
        TAP_STAGE,
        TAP_LAST
    } t_tapop;

    typedef struct packed {
        logic   mul_en;
        t_asel  a_sel;
        t_bsel  b_sel;
        t_accop acc_op;
        t_tapop tap_op;
        logic   deemph_wr;
        logic   kz_wr;
        logic   hp_wr;
        logic   emit;
        logic   loop_jmp;
        t_step  jmp_to;
        logic   done;
    } t_uword;

    localparam t_uword UW_NOP = '{
        mul_en:    1'b0,
        a_sel:     A_FINP,
        b_sel:     B_EGAIN,
        acc_op:    ACC_HOLD,
        tap_op:    TAP_HOLD,
        deemph_wr: 1'b0,
        kz_wr:     1'b0,
        hp_wr:     1'b0,
        emit:      1'b0,
        loop_jmp:  1'b0,
        jmp_to:    ST_EXC,
        done:      1'b0
    };

    function automatic t_uword rom_word(input t_step step);
        t_uword w;
        w = UW_NOP;
        case (step)
            ST_EXC: begin
                w.mul_en = 1'b1; w.a_sel = A_FINP; w.b_sel = B_EGAIN;
            end
            ST_C0: begin
                w.mul_en = 1'b1; w.a_sel = A_TAP0; w.b_sel = B_COEF0;
                w.acc_op = ACC_LOAD; w.tap_op = TAP_KEEP;
            end
            ST_C1: begin
                w.mul_en = 1'b1; w.a_sel = A_TAP0; w.b_sel = B_COEF0;
                w.acc_op = ACC_SUB;
            end
            ST_LOOP: begin
                w.acc_op = ACC_SUB;
            end
            ST_SMUL: begin
                w.mul_en = 1'b1; w.a_sel = A_ACC_SH; w.b_sel = B_COEF0;
            end
            ST_SWR: begin
                w.mul_en = 1'b1; w.a_sel = A_TAP1; w.b_sel = B_COEF1;
                w.tap_op = TAP_STAGE; w.loop_jmp = 1'b1; w.jmp_to = ST_LOOP;
            end
            ST_LAST: begin
                w.mul_en = 1'b1; w.a_sel = A_ACC_SH; w.b_sel = B_OGAIN;
                w.tap_op = TAP_LAST;
            end
            ST_DEEMPH: begin
                w.mul_en = 1'b1; w.a_sel = A_DEEMPH; w.b_sel = B_DEEMPH_K;
                w.acc_op = ACC_LOAD;
            end
            ST_MIX: begin
                w.acc_op = ACC_ADD_SH4;
            end
            ST_KZ: begin
                w.deemph_wr = 1'b1; w.kz_wr = 1'b1;
            end
            ST_EMIT: begin
                w.mul_en = 1'b1; w.a_sel = A_KZ_SH; w.b_sel = B_HIPASS_K;
                w.emit = 1'b1;
            end
            ST_HP: begin
                w.hp_wr = 1'b1; w.done = 1'b1;
            end
            default: begin
                w = UW_NOP;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [FINW-1:0] pulse_tap(input logic [4:0] k);
        logic signed [FINW-1:0] v;
        case (k)
            5'd0:    v = 16'sd4608;
            5'd2:    v = 16'sd3584;
            5'd4:    v = 16'sd6656;
            5'd6:    v = 16'sd20992;
            5'd8:    v = -16'sd20992;
            5'd10:   v = -16'sd6656;
            5'd12:   v = -16'sd3584;
            5'd14:   v = -16'sd4608;
            default: v = '0;
        endcase
        return v;
    endfunction

    // x mod 10240: low 11 bits pass, upper 21 bits reduced mod 5 by nibble sum
    function automatic logic [13:0] noise_mod(input logic [DW-1:0] x);
        logic [6:0]  s;
        logic [14:0] q;
        logic [2:0]  r;
        s = 7'(x[14:11]) + 7'(x[18:15]) + 7'(x[22:19]) + 7'(x[26:23])
          + 7'(x[30:27]) + 7'(x[31]);
        q = (15'(s) * 15'd205) >> 10;
        r = 3'(s - 7'(q) * 7'd5);
        return {r, x[10:0]};
    endfunction

endpackage

>>> src/lpcs_if.sv
`timescale 1ns / 1ps
// Stream interfaces: parameter beats in, sample beats out.
interface lpcs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          frame_start;
    logic signed [lpcs_pkg::CW-1:0] refl_0;
    logic signed [lpcs_pkg::CW-1:0] refl_1;
    logic signed [lpcs_pkg::CW-1:0] refl_2;
    logic signed [lpcs_pkg::CW-1:0] refl_3;
    logic signed [lpcs_pkg::CW-1:0] refl_4;
    logic signed [lpcs_pkg::CW-1:0] refl_5;
    logic signed [lpcs_pkg::CW-1:0] refl_6;
    logic signed [lpcs_pkg::CW-1:0] refl_7;
    logic [lpcs_pkg::PERW-1:0]      pitch_period;
    logic [lpcs_pkg::EGW-1:0]       excite_gain;
    logic signed [lpcs_pkg::CW-1:0] output_gain;

    modport source (
        output valid, frame_start, refl_0, refl_1, refl_2, refl_3, refl_4, refl_5,
               refl_6, refl_7, pitch_period, excite_gain, output_gain,
        input  ready
    );
    modport sink (
        input  valid, frame_start, refl_0, refl_1, refl_2, refl_3, refl_4, refl_5,
               refl_6, refl_7, pitch_period, excite_gain, output_gain,
        output ready
    );
endinterface

interface lpcs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lpcs_pkg::SAMPW-1:0] sample;

    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

>>> src/lpc_lattice_speech_synth_core.sv
`timescale 1ns / 1ps
// Top level: LPC lattice speech synthesizer, one sample beat per parameter beat.
//
//  channel | dir | handshake          | payload
//  i_in    | in  | valid/ready (sink) | frame_start, refl_0..refl_7, pitch_period,
//          |     |                    | excite_gain, output_gain
//  o_out   | out | valid/ready (src)  | sample (21 bit signed)
//
//  One beat runs 3 + 3*(ORDER-1) + 6 microcode steps (30 at ORDER = 8) on one shared
//  32x17 multiplier; no new beat is taken until the last one is done.
//  Three steps per lattice stage are set by the registered multiplier product.
//  Synchronous active-low reset clears the lattice, filters and pitch state and sets the LFSR to 1.
//  i_in.ready is low while a beat is in work; a stalled o_out holds the emit step.
module lpc_lattice_speech_synth_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpcs_in_if.sink     i_in,
    lpcs_out_if.source  o_out
);

    logic                                  busy;
    logic                                  accept;
    logic                                  clear;
    logic signed [lpcs_pkg::FINW-1:0]      finp;
    lpcs_pkg::t_coef_arr                   coef;
    logic [lpcs_pkg::NREFL-1:0][lpcs_pkg::CW-1:0] refl;
    lpcs_pkg::t_uword                      uw;
    logic [lpcs_pkg::SAMPW-1:0]            dp_sample;
    logic                                  r_out_valid;
    logic [lpcs_pkg::SAMPW-1:0]            r_out_sample;

    assign refl = {i_in.refl_7, i_in.refl_6, i_in.refl_5, i_in.refl_4,
                   i_in.refl_3, i_in.refl_2, i_in.refl_1, i_in.refl_0};

    for (genvar j = 0; j < lpcs_pkg::ORDER; j++) begin : g_coef
        if (j < lpcs_pkg::NREFL) begin : g_used
            assign coef[j] = refl[lpcs_pkg::NREFL-1-j];
        end else begin : g_zero
            assign coef[j] = '0;
        end
    end

    assign i_in.ready = !busy;
    assign accept     = i_in.valid && !busy;

    lpcs_exc u_exc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_frame_start (i_in.frame_start),
        .i_period      (i_in.pitch_period),
        .o_finp        (finp),
        .o_clear       (clear)
    );

    lpcs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_out_free (!r_out_valid || o_out.ready),
        .o_busy     (busy),
        .o_uw       (uw)
    );

    lpcs_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_clear  (clear),
        .i_finp   (finp),
        .i_coef   (coef),
        .i_egain  (i_in.excite_gain),
        .i_ogain  (i_in.output_gain),
        .i_uw     (uw),
        .o_sample (dp_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.emit) begin
            r_out_sample <= dp_sample;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.sample = $signed(r_out_sample);

endmodule

>>> src/lpcs_exc.sv
`timescale 1ns / 1ps
// Excitation: pitch counter, pulse index, noise LFSR and frame realignment.
module lpcs_exc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_frame_start,
    input  logic [lpcs_pkg::PERW-1:0]           i_period,
    output logic signed [lpcs_pkg::FINW-1:0]    o_finp,
    output logic                                o_clear
);

    lpcs_pkg::t_pcnt           r_pc, n_pc;
    lpcs_pkg::t_pidx           r_pi, n_pi;
    logic [lpcs_pkg::PERW-1:0] r_lp, n_lp;
    logic [lpcs_pkg::DW-1:0]   r_lfsr, n_lfsr;
    logic signed [13:0]        sum;

    assign sum = $signed({2'b00, r_pc}) + $signed({3'b000, i_period})
               - $signed({3'b000, r_lp});

    always_comb begin
        n_pc    = r_pc;
        n_pi    = r_pi;
        n_lp    = r_lp;
        n_lfsr  = r_lfsr;
        o_clear = 1'b0;
        o_finp  = '0;
        if (i_frame_start) begin
            if (i_period != '0) begin
                if (r_pc != '0 && !sum[13] && sum != '0) begin
                    n_pc = sum[11:0];
                end
            end else begin
                n_pc = '0;
            end
            o_clear = (r_lp == '0) && (i_period != '0);
            n_pi    = '0;
            n_lp    = i_period;
        end
        if (i_period == '0) begin
            n_lfsr = {1'b0, r_lfsr[lpcs_pkg::DW-1:1]}
                   ^ (r_lfsr[0] ? lpcs_pkg::LFSR_TAPS : '0);
            o_finp = $signed({2'b00, lpcs_pkg::noise_mod(n_lfsr)}) - lpcs_pkg::NOISE_HALF;
        end else begin
            if (n_pc == '0) begin
                n_pc   = lpcs_pkg::t_pcnt'(i_period);
                o_finp = lpcs_pkg::pulse_tap(5'd0);
                n_pi   = lpcs_pkg::t_pidx'(1);
            end else if (n_pi < lpcs_pkg::t_pidx'(lpcs_pkg::PULSE_LEN)) begin
                o_finp = lpcs_pkg::pulse_tap(5'(n_pi));
                n_pi   = n_pi + lpcs_pkg::t_pidx'(1);
            end
            n_pc = n_pc - lpcs_pkg::t_pcnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_pi   <= '0;
            r_lp   <= '0;
            r_lfsr <= lpcs_pkg::DW'(1);
        end else if (i_start) begin
            r_pc   <= n_pc;
            r_pi   <= n_pi;
            r_lp   <= n_lp;
            r_lfsr <= n_lfsr;
        end
    end

endmodule

>>> src/lpcs_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program ROM, lattice loop counter.
module lpcs_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_out_free,
    output logic             o_busy,
    output lpcs_pkg::t_uword o_uw
);

    logic              r_busy;
    lpcs_pkg::t_step   r_step;
    lpcs_pkg::t_loop   r_loop;
    lpcs_pkg::t_uword  uw;
    logic              adv;

    assign uw     = lpcs_pkg::rom_word(r_step);
    assign adv    = r_busy && (!uw.emit || i_out_free);
    assign o_uw   = adv ? uw : lpcs_pkg::UW_NOP;
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= lpcs_pkg::ST_EXC;
            r_loop <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= lpcs_pkg::ST_EXC;
            r_loop <= '0;
        end else if (adv) begin
            if (uw.done) begin
                r_busy <= 1'b0;
                r_step <= lpcs_pkg::ST_EXC;
            end else if (uw.loop_jmp) begin
                r_loop <= r_loop + lpcs_pkg::t_loop'(1);
                r_step <= (r_loop != lpcs_pkg::LOOP_LAST) ? uw.jmp_to
                                                          : r_step + lpcs_pkg::t_step'(1);
            end else begin
                r_step <= r_step + lpcs_pkg::t_step'(1);
            end
        end
    end

endmodule

>>> src/lpcs_dp.sv
`timescale 1ns / 1ps
// Datapath: shared multiplier, accumulator, rotating tap and coefficient lines, filters.
module lpcs_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_clear,
    input  logic signed [lpcs_pkg::FINW-1:0]  i_finp,
    input  lpcs_pkg::t_coef_arr               i_coef,
    input  logic [lpcs_pkg::EGW-1:0]          i_egain,
    input  logic signed [lpcs_pkg::CW-1:0]    i_ogain,
    input  lpcs_pkg::t_uword                  i_uw,
    output logic [lpcs_pkg::SAMPW-1:0]        o_sample
);

    lpcs_pkg::t_coef_arr             r_cring;
    lpcs_pkg::t_tap_arr              r_taps;
    logic [lpcs_pkg::EGW-1:0]        r_egain;
    logic signed [lpcs_pkg::CW-1:0]  r_ogain;
    logic signed [lpcs_pkg::FINW-1:0] r_finp;
    logic signed [lpcs_pkg::DW-1:0]  r_acc;
    logic signed [lpcs_pkg::DW-1:0]  r_prod;
    logic signed [lpcs_pkg::DW-1:0]  r_deemph;
    logic signed [lpcs_pkg::DW-1:0]  r_hp;
    logic signed [lpcs_pkg::DW-1:0]  r_kz;

    logic signed [lpcs_pkg::DW-1:0]        mul_a;
    logic signed [lpcs_pkg::BW-1:0]        mul_b;
    logic signed [lpcs_pkg::DW+lpcs_pkg::BW-1:0] mul_full;
    logic [lpcs_pkg::DW-1:0]               n_push;

    always_comb begin
        case (i_uw.a_sel)
            lpcs_pkg::A_FINP:   mul_a = lpcs_pkg::DW'(r_finp);
            lpcs_pkg::A_TAP0:   mul_a = $signed(r_taps[0]);
            lpcs_pkg::A_TAP1:   mul_a = $signed(r_taps[1]);
            lpcs_pkg::A_ACC_SH: mul_a = r_acc >>> 15;
            lpcs_pkg::A_DEEMPH: mul_a = r_deemph;
            lpcs_pkg::A_KZ_SH:  mul_a = r_kz >>> 15;
            default:            mul_a = '0;
        endcase
    end

    always_comb begin
        case (i_uw.b_sel)
            lpcs_pkg::B_EGAIN:    mul_b = $signed({2'b00, r_egain});
            lpcs_pkg::B_COEF0:    mul_b = lpcs_pkg::BW'($signed(r_cring[0]));
            lpcs_pkg::B_COEF1:    mul_b = lpcs_pkg::BW'($signed(r_cring[1]));
            lpcs_pkg::B_OGAIN:    mul_b = lpcs_pkg::BW'(r_ogain);
            lpcs_pkg::B_DEEMPH_K: mul_b = lpcs_pkg::DEEMPH_K;
            lpcs_pkg::B_HIPASS_K: mul_b = lpcs_pkg::HIPASS_K;
            default:              mul_b = '0;
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_comb begin
        case (i_uw.tap_op)
            lpcs_pkg::TAP_KEEP:  n_push = r_taps[0];
            lpcs_pkg::TAP_STAGE: n_push = lpcs_pkg::DW'((r_prod >>> 15) + $signed(r_taps[0]));
            lpcs_pkg::TAP_LAST:  n_push = lpcs_pkg::DW'(r_acc >>> 15);
            default:             n_push = r_taps[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps   <= '0;
            r_deemph <= '0;
            r_hp     <= '0;
        end else begin
            if (i_start && i_clear) begin
                r_taps <= '0;
            end else if (i_uw.tap_op != lpcs_pkg::TAP_HOLD) begin
                r_taps <= {n_push, r_taps[lpcs_pkg::ORDER-1:1]};
            end
            if (i_uw.deemph_wr) begin
                r_deemph <= r_acc >>> 11;
            end
            if (i_uw.hp_wr) begin
                r_hp <= r_prod - r_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cring <= i_coef;
            r_egain <= i_egain;
            r_ogain <= i_ogain;
            r_finp  <= i_finp;
        end else if (i_uw.tap_op != lpcs_pkg::TAP_HOLD) begin
            r_cring <= {r_cring[0], r_cring[lpcs_pkg::ORDER-1:1]};
        end
        if (i_uw.mul_en) begin
            r_prod <= mul_full[lpcs_pkg::DW-1:0];
        end
        case (i_uw.acc_op)
            lpcs_pkg::ACC_LOAD:    r_acc <= r_prod;
            lpcs_pkg::ACC_SUB:     r_acc <= r_acc - r_prod;
            lpcs_pkg::ACC_ADD_SH4: r_acc <= r_acc + (r_prod >>> 4);
            default:               r_acc <= r_acc;
        endcase
        if (i_uw.kz_wr) begin
            r_kz <= r_hp + r_acc;
        end
    end

    assign o_sample = r_kz[lpcs_pkg::DW-1:11];

endmodule

>>> src/lpcs_chk.sv
`timescale 1ns / 1ps
// Port checker for the synthesizer top level, attached by bind.
module lpcs_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [lpcs_pkg::SAMPW-1:0]   i_out_sample
);

    logic [1:0] r_pending, n_pending;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (in_beat && !out_beat) begin
            n_pending = r_pending + 2'd1;
        end else if (out_beat && !in_beat) begin
            n_pending = r_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample))
        else $error("output beat dropped or changed while stalled");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in_ready)
        else $error("input taken while a beat is in work");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("output beat without a matching input beat");

    a_idle_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> r_pending <= 2'd1)
        else $error("idle with more than one beat outstanding");

endmodule

bind lpc_lattice_speech_synth_core lpcs_chk u_lpcs_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample)
);
